// ===== rtl/rwc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_pkg: request window controller shared definitions
// Event codes, reset constants, fixed-point divider constants and the
// structs passed between the demand pipeline and the window state.
// ----------------------------------------------------------------------------
package rwc_pkg;

    typedef enum logic [3:0] {
        OP_INCREMENT    = 4'd0,
        OP_DECREMENT    = 4'd1,
        OP_BURST        = 4'd2,
        OP_WITHHOLD     = 4'd3,
        OP_MARK_LOWER   = 4'd4,
        OP_DELAY_UPDATE = 4'd5,
        OP_RATE_UPDATE  = 4'd6,
        OP_INITIALIZE   = 4'd7,
        OP_CLEAR        = 4'd8
    } op_t;

    localparam int unsigned UPPER_FACTOR_DEF = 8;

    localparam logic [7:0]  MIN_WINDOW_RST = 8'd6;
    localparam logic [15:0] RESET_UPPER    = 16'(10 * int'(MIN_WINDOW_RST));
    localparam logic [15:0] CLEAR_UPPER    = 16'd30;

    // demand fits 13 bits, which is also its saturation point (8191)
    localparam int unsigned DEMAND_W = 13;

    // ceil(S / 480) = floor((S + 479) * 139811 / 2^26), exact for S < 2^17
    localparam int unsigned PERIOD_BIAS  = 479;
    localparam int unsigned PERIOD_RECIP = 139811;
    localparam int unsigned PERIOD_SHIFT = 26;
    localparam int unsigned PERIOD_Q_W   = 10;

    // ceil(P / 4096000) = ceil(ceil(P / 4096) / 1000)
    // ceil(Q / 1000) = floor((Q + 999) * 2147484 / 2^31), exact for Q < 2^22
    localparam int unsigned RATE_FRAC_BITS = 12;
    localparam int unsigned RATE_BIAS      = 999;
    localparam int unsigned RATE_RECIP     = 2147484;
    localparam int unsigned RATE_SHIFT     = 31;

    typedef struct packed {
        op_t         op;
        logic [15:0] value;
    } item_t;

    typedef struct packed {
        item_t               item;
        logic [DEMAND_W-1:0] lower;
        logic [15:0]         upper;
    } dmd_t;

endpackage

// ===== rtl/request_window_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_window_controller: outstanding request window control
// Counts outstanding requests against a window limit and adapts the
// window bounds to the delay statistics and the target rate.
// ----------------------------------------------------------------------------
// Takes one event request per cycle while s_ready is high and returns one
// result per request, in order: ok plus the outstanding count, window,
// lower and upper bound after the event. The demand pipeline (sum, rate
// product, reciprocal divide, clamp) sits ahead of the state update, which
// is a single register stage, so each request sees the state left by the
// one before it. Results sit in an output register; while it holds an
// untaken result the pipeline keeps accepting requests until its four
// stages are full. min_window is written through cfg_wr_en/cfg_wr_data and
// should change only while no request is in flight.
// ----------------------------------------------------------------------------
module request_window_controller #(
    parameter int unsigned UPPER_FACTOR = rwc_pkg::UPPER_FACTOR_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_op,
    input  logic [15:0] s_value,
    input  logic [15:0] s_rate,
    input  logic [15:0] s_delay_avg,
    input  logic [15:0] s_delay_dev,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [15:0] m_outstanding,
    output logic [15:0] m_window,
    output logic [15:0] m_lower_bound,
    output logic [15:0] m_upper_bound
);

    rwc_pkg::item_t s_item;
    rwc_pkg::dmd_t  dmd;
    logic           dmd_valid;
    logic           dmd_ready;
    logic           load;

    // config and window state; the state registers also drive the outputs
    logic [7:0]  min_window_reg;
    logic [15:0] outstanding_reg, outstanding_next;
    logic [15:0] window_reg, window_next;
    logic [15:0] lower_reg, lower_next;
    logic [15:0] upper_reg, upper_next;
    logic        started_reg, started_next;
    logic        pinned_reg, pinned_next;
    logic        ok_reg, ok_next;
    logic        m_valid_reg;

    // limit update terms
    logic [15:0] min16;
    logic [15:0] nl16;
    logic [15:0] lower_src;
    logic        pinned_src;
    logic        lim_changed;
    logic [15:0] ap_lower, ap_upper, ap_window;
    logic [15:0] lower_cand;

    // burst / withhold / initialize terms
    logic [16:0] burst_half, burst_want;
    logic [16:0] wh_gap, wh_shrink, wh_want;
    logic [15:0] init_upper;

    // with inverted bounds, values under lo give lo and all others give hi
    function automatic logic [15:0] clamp_win(input logic [16:0] want,
                                              input logic [15:0] lo,
                                              input logic [15:0] hi);
        logic [15:0] res;
        if (want < {1'b0, lo}) begin
            res = lo;
        end else if (want > {1'b0, hi}) begin
            res = hi;
        end else begin
            res = want[15:0];
        end
        return res;
    endfunction

    assign s_item.op    = rwc_pkg::op_t'(s_op);
    assign s_item.value = s_value;

    rwc_demand #(
        .UPPER_FACTOR (UPPER_FACTOR)
    ) u_demand (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_valid),
        .in_ready     (s_ready),
        .in_item      (s_item),
        .in_rate      (s_rate),
        .in_delay_avg (s_delay_avg),
        .in_delay_dev (s_delay_dev),
        .min_window   (min_window_reg),
        .out_valid    (dmd_valid),
        .out_ready    (dmd_ready),
        .out_dmd      (dmd)
    );

    // output register takes a new result when empty or being drained
    assign dmd_ready = !m_valid_reg || m_ready;
    assign load      = dmd_valid && dmd_ready;

    // applying limits: mark_lower applies on top of its own lower bound
    always_comb begin
        min16      = {8'd0, min_window_reg};
        nl16       = 16'(dmd.lower);
        lower_src  = (dmd.item.op == rwc_pkg::OP_MARK_LOWER) ? dmd.item.value : lower_reg;
        pinned_src = (dmd.item.op == rwc_pkg::OP_MARK_LOWER) ? 1'b1 : pinned_reg;
        lim_changed = (lower_src != nl16) || (upper_reg != dmd.upper);
        lower_cand = (!pinned_src || nl16 > lower_src) ? nl16 : lower_src;
        if (lim_changed) begin
            ap_lower  = lower_cand;
            ap_upper  = dmd.upper;
            ap_window = (window_reg < lower_cand)
                      ? clamp_win({1'b0, lower_cand}, lower_cand, dmd.upper)
                      : window_reg;
        end else begin
            ap_lower  = lower_src;
            ap_upper  = upper_reg;
            ap_window = window_reg;
        end
    end

    always_comb begin
        burst_half = ({1'b0, window_reg} + 17'd1) >> 1;
        burst_want = {1'b0, window_reg} + burst_half;
        wh_gap     = {1'b0, window_reg} - {1'b0, lower_reg} + 17'd1;
        wh_shrink  = (window_reg >= lower_reg) ? (wh_gap >> 1) : 17'd0;
        wh_want    = {1'b0, window_reg} - wh_shrink;
        init_upper = (dmd.item.value > upper_reg) ? dmd.item.value : upper_reg;
    end

    always_comb begin
        outstanding_next = outstanding_reg;
        window_next      = window_reg;
        lower_next       = lower_reg;
        upper_next       = upper_reg;
        started_next     = started_reg;
        pinned_next      = pinned_reg;
        ok_next          = 1'b1;
        case (dmd.item.op)
            rwc_pkg::OP_INCREMENT: begin
                if (outstanding_reg >= window_reg) begin
                    ok_next = 1'b0;
                end else begin
                    outstanding_next = outstanding_reg + 16'd1;
                end
            end
            rwc_pkg::OP_DECREMENT: begin
                if (outstanding_reg == 16'd0) begin
                    ok_next = 1'b0;
                end else begin
                    outstanding_next = outstanding_reg - 16'd1;
                end
            end
            rwc_pkg::OP_BURST: begin
                if (started_reg) begin
                    window_next = clamp_win(burst_want, lower_reg, upper_reg);
                end else begin
                    ok_next = 1'b0;
                end
            end
            rwc_pkg::OP_WITHHOLD: begin
                if (started_reg && wh_shrink != 17'd0) begin
                    window_next = clamp_win(wh_want, lower_reg, upper_reg);
                end else begin
                    ok_next = 1'b0;
                end
            end
            rwc_pkg::OP_MARK_LOWER: begin
                pinned_next = 1'b1;
                lower_next  = ap_lower;
                upper_next  = ap_upper;
                window_next = ap_window;
            end
            rwc_pkg::OP_DELAY_UPDATE: begin
                if (started_reg) begin
                    lower_next  = ap_lower;
                    upper_next  = ap_upper;
                    window_next = ap_window;
                end
            end
            rwc_pkg::OP_RATE_UPDATE: begin
                started_next = 1'b1;
                lower_next   = ap_lower;
                upper_next   = ap_upper;
                window_next  = ap_window;
            end
            rwc_pkg::OP_INITIALIZE: begin
                lower_next  = min16;
                upper_next  = init_upper;
                window_next = clamp_win({1'b0, dmd.item.value}, min16, init_upper);
            end
            rwc_pkg::OP_CLEAR: begin
                started_next     = 1'b0;
                pinned_next      = 1'b0;
                outstanding_next = 16'd0;
                lower_next       = min16;
                window_next      = min16;
                upper_next       = rwc_pkg::CLEAR_UPPER;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_window_reg  <= rwc_pkg::MIN_WINDOW_RST;
            outstanding_reg <= '0;
            window_reg      <= {8'd0, rwc_pkg::MIN_WINDOW_RST};
            lower_reg       <= {8'd0, rwc_pkg::MIN_WINDOW_RST};
            upper_reg       <= rwc_pkg::RESET_UPPER;
            started_reg     <= 1'b0;
            pinned_reg      <= 1'b0;
            ok_reg          <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                min_window_reg <= cfg_wr_data;
            end
            if (load) begin
                outstanding_reg <= outstanding_next;
                window_reg      <= window_next;
                lower_reg       <= lower_next;
                upper_reg       <= upper_next;
                started_reg     <= started_next;
                pinned_reg      <= pinned_next;
                ok_reg          <= ok_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_ok          = ok_reg;
    assign m_outstanding = outstanding_reg;
    assign m_window      = window_reg;
    assign m_lower_bound = lower_reg;
    assign m_upper_bound = upper_reg;

`ifndef ASSERT_OFF
    // back-pressure on the input only comes from a stalled result
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid_reg && !m_ready))
        else $error("input stalled without a stalled result");

    // a refused request leaves count and bounds alone
    a_refused_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && !ok_next) |=> ($stable(outstanding_reg) && $stable(window_reg)
                                && $stable(lower_reg) && $stable(upper_reg)))
        else $error("refused request changed window state");

    // started drops only on clear
    a_started_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (started_reg && !(load && dmd.item.op == rwc_pkg::OP_CLEAR)) |=> started_reg)
        else $error("started flag dropped without clear");

    // state moves only when a result is loaded
    a_state_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !load |=> ($stable(outstanding_reg) && $stable(window_reg)
                   && $stable(lower_reg) && $stable(upper_reg)))
        else $error("window state changed without a result");
`endif

endmodule

// ===== rtl/rwc_demand.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwc_demand: interest demand pipeline
// Four-stage pipeline that carries each request and computes the demand
// and upper bound it would apply, from the delay and rate statistics.
// ----------------------------------------------------------------------------
module rwc_demand #(
    parameter int unsigned UPPER_FACTOR = rwc_pkg::UPPER_FACTOR_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  rwc_pkg::item_t     in_item,
    input  logic [15:0]        in_rate,
    input  logic [15:0]        in_delay_avg,
    input  logic [15:0]        in_delay_dev,
    input  logic [7:0]         min_window,
    output logic               out_valid,
    input  logic               out_ready,
    output rwc_pkg::dmd_t      out_dmd
);

    localparam int unsigned DW       = rwc_pkg::DEMAND_W;
    localparam int unsigned FACTOR_W = $clog2(UPPER_FACTOR + 1);
    localparam int unsigned PROD_W   = DW + FACTOR_W;
    localparam int unsigned NU_W     = (PROD_W > 17) ? PROD_W : 17;
    localparam int unsigned PQW      = rwc_pkg::PERIOD_Q_W;

    // statistics, updated as requests enter
    logic [15:0] rate_reg, rate_next;
    logic [15:0] avg_reg, avg_next;
    logic [15:0] dev_reg, dev_next;

    logic accept;

    // stage A: operands
    logic            va_reg;
    rwc_pkg::item_t  item_a_reg;
    logic [16:0]     sum_a_reg, sum_a_next;
    logic [15:0]     rate_a_reg;
    logic            avgz_a_reg, avgz_a_next;

    // stage B: products
    logic            vb_reg;
    rwc_pkg::item_t  item_b_reg;
    logic [32:0]     prod_b_reg, prod_b_next;
    logic [PQW-1:0]  perq_b_reg, perq_b_next;
    logic            rzero_b_reg, rzero_b_next;
    logic            avgz_b_reg;
    logic [17:0]     period_x;
    logic [35:0]     period_prod;

    // stage C: rate quotient
    logic            vc_reg;
    rwc_pkg::item_t  item_c_reg;
    logic [DW-1:0]   rateq_c_reg, rateq_c_next;
    logic [PQW-1:0]  perq_c_reg;
    logic            rzero_c_reg;
    logic            avgz_c_reg;
    logic [21:0]     rate_ceil;
    logic [21:0]     rate_x;
    logic [43:0]     rate_prod;

    // stage D: bounds
    logic            vd_reg;
    rwc_pkg::item_t  item_d_reg;
    logic [DW-1:0]   nl_d_reg, nl_d_next;
    logic [15:0]     nu_d_reg, nu_d_next;
    logic [DW-1:0]   raw_d;
    logic [DW-1:0]   min_d;
    logic [NU_W-1:0] nu_full;

    logic en_a, en_b, en_c, en_d;

    assign en_d     = !vd_reg || out_ready;
    assign en_c     = !vc_reg || en_d;
    assign en_b     = !vb_reg || en_c;
    assign en_a     = !va_reg || en_b;
    assign in_ready = en_a;
    assign accept   = in_valid && en_a;

    // a rate update uses its own rate, a delay update its own delays
    always_comb begin
        rate_next = rate_reg;
        avg_next  = avg_reg;
        dev_next  = dev_reg;
        if (accept && in_item.op == rwc_pkg::OP_RATE_UPDATE) begin
            rate_next = in_rate;
        end
        if (accept && in_item.op == rwc_pkg::OP_DELAY_UPDATE) begin
            avg_next = in_delay_avg;
            dev_next = in_delay_dev;
        end
        sum_a_next  = {1'b0, avg_next} + {1'b0, dev_next};
        avgz_a_next = (avg_next == 16'd0);
    end

    always_comb begin
        prod_b_next  = 33'(sum_a_reg) * 33'(rate_a_reg);
        period_x     = {1'b0, sum_a_reg} + 18'(rwc_pkg::PERIOD_BIAS);
        period_prod  = 36'(period_x) * 36'(rwc_pkg::PERIOD_RECIP);
        perq_b_next  = period_prod[rwc_pkg::PERIOD_SHIFT +: PQW];
        rzero_b_next = (rate_a_reg == 16'd0);
    end

    always_comb begin
        rate_ceil    = 22'(prod_b_reg[32:rwc_pkg::RATE_FRAC_BITS])
                     + 22'(|prod_b_reg[rwc_pkg::RATE_FRAC_BITS-1:0]);
        rate_x       = rate_ceil + 22'(rwc_pkg::RATE_BIAS);
        rate_prod    = 44'(rate_x) * 44'(rwc_pkg::RATE_RECIP);
        rateq_c_next = rate_prod[rwc_pkg::RATE_SHIFT +: DW];
    end

    // 13-bit demand cannot pass 8191, so saturation is implicit
    always_comb begin
        min_d = DW'(min_window);
        if (avgz_c_reg) begin
            raw_d = min_d;
        end else if (rzero_c_reg) begin
            raw_d = DW'(perq_c_reg);
        end else begin
            raw_d = rateq_c_reg;
        end
        nl_d_next = (raw_d < min_d) ? min_d : raw_d;
        nu_full   = NU_W'(nl_d_next) * NU_W'(UPPER_FACTOR);
        nu_d_next = (nu_full > NU_W'(16'hFFFF)) ? 16'hFFFF : nu_full[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= '0;
            avg_reg  <= '0;
            dev_reg  <= '0;
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            vc_reg   <= 1'b0;
            vd_reg   <= 1'b0;
        end else begin
            rate_reg <= rate_next;
            avg_reg  <= avg_next;
            dev_reg  <= dev_next;
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
            if (en_d) vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            item_a_reg <= in_item;
            sum_a_reg  <= sum_a_next;
            rate_a_reg <= rate_next;
            avgz_a_reg <= avgz_a_next;
        end
        if (en_b) begin
            item_b_reg  <= item_a_reg;
            prod_b_reg  <= prod_b_next;
            perq_b_reg  <= perq_b_next;
            rzero_b_reg <= rzero_b_next;
            avgz_b_reg  <= avgz_a_reg;
        end
        if (en_c) begin
            item_c_reg  <= item_b_reg;
            rateq_c_reg <= rateq_c_next;
            perq_c_reg  <= perq_b_reg;
            rzero_c_reg <= rzero_b_reg;
            avgz_c_reg  <= avgz_b_reg;
        end
        if (en_d) begin
            item_d_reg <= item_c_reg;
            nl_d_reg   <= nl_d_next;
            nu_d_reg   <= nu_d_next;
        end
    end

    assign out_valid     = vd_reg;
    assign out_dmd.item  = item_d_reg;
    assign out_dmd.lower = nl_d_reg;
    assign out_dmd.upper = nu_d_reg;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: request window controller testbench
// Drives event requests into the controller, predicts every result from its
// own model of the window state and compares each result in order. Directed
// tests for the corner cases come first, then random traffic at several
// min_window settings, with random idling and one long output stall.
// ----------------------------------------------------------------------------
module tb;

    // run control
    localparam int unsigned RESET_CYCLES   = 6;
    localparam int unsigned DRAIN_CYCLES   = 10;   // extra slack after the last result
    localparam int unsigned LONG_HOLD      = 64;   // receiver hold-off, fills the pipe
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned MAX_REPORTS    = 10;

    // op codes the block does not know
    localparam logic [3:0] OP_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] OP_UNKNOWN_HI = 4'd15;

    // demand arithmetic: 12.4 ms times 8.8 fps over 1000 ms, 30 ms period at rate 0
    localparam longint unsigned RATE_DIV   = 64'd4096000;
    localparam longint unsigned PERIOD_DIV = 64'd480;
    localparam longint unsigned DEMAND_CAP = (64'd1 << rwc_pkg::DEMAND_W) - 1;
    localparam int unsigned     UPPER_MULT = rwc_pkg::UPPER_FACTOR_DEF;

    typedef struct packed {
        logic        ok;
        logic [15:0] outstanding;
        logic [15:0] window;
        logic [15:0] lower;
        logic [15:0] upper;
    } window_status_t;

    // ------------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = rwc_pkg::MIN_WINDOW_RST;
    logic        s_valid     = 1'b0;
    logic [3:0]  s_op        = 4'd0;
    logic [15:0] s_value     = 16'd0;
    logic [15:0] s_rate      = 16'd0;
    logic [15:0] s_delay_avg = 16'd0;
    logic [15:0] s_delay_dev = 16'd0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ok;
    logic [15:0] m_outstanding;
    logic [15:0] m_window;
    logic [15:0] m_lower_bound;
    logic [15:0] m_upper_bound;

    request_window_controller uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_value       (s_value),
        .s_rate        (s_rate),
        .s_delay_avg   (s_delay_avg),
        .s_delay_dev   (s_delay_dev),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_outstanding (m_outstanding),
        .m_window      (m_window),
        .m_lower_bound (m_lower_bound),
        .m_upper_bound (m_upper_bound)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Window state model, advanced once per request at the time it is sent.
    // Requests are accepted in send order, so this matches the DUT's view.
    // ------------------------------------------------------------------------
    bit [7:0]  min_window_cfg  = rwc_pkg::MIN_WINDOW_RST;
    bit [15:0] win_outstanding = 16'd0;
    bit [15:0] win_limit       = 16'(rwc_pkg::MIN_WINDOW_RST);
    bit [15:0] win_lower       = 16'(rwc_pkg::MIN_WINDOW_RST);
    bit [15:0] win_upper       = rwc_pkg::RESET_UPPER;
    bit        win_started     = 1'b0;
    bit        win_pinned      = 1'b0;
    bit [15:0] stat_rate       = 16'd0;
    bit [15:0] stat_avg        = 16'd0;
    bit [15:0] stat_dev        = 16'd0;

    window_status_t pending_results[$];

    // run bookkeeping
    int unsigned requests_sent   = 0;
    int unsigned unknown_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned refusals        = 0;
    int unsigned mismatches      = 0;
    int unsigned settings_used   = 1;
    int unsigned quiet_cycles    = 0;

    // idling and hold-off controls, changed only on the falling edge
    bit idle_on  = 1'b0;
    int hold_seq = 0;

    // Clamp order matters: below lower wins first, so inverted bounds give
    // the lower bound only for values under it.
    function automatic bit [15:0] clamp_window(input int unsigned want);
        if (want < win_lower)
            return win_lower;
        if (want > win_upper)
            return win_upper;
        return want[15:0];
    endfunction

    // Recompute demand and move the bounds; only acts when they would change.
    function automatic void retarget_bounds();
        longint unsigned span;
        longint unsigned need;
        longint unsigned top;
        bit [15:0]       want_lo;
        bit [15:0]       want_hi;
        need = 64'(min_window_cfg);
        if (stat_avg != 16'd0) begin
            span = 64'(stat_avg) + 64'(stat_dev);
            if (stat_rate != 16'd0)
                need = (span * 64'(stat_rate) + RATE_DIV - 1) / RATE_DIV;
            else
                need = (span + PERIOD_DIV - 1) / PERIOD_DIV;
        end
        if (need < 64'(min_window_cfg))
            need = 64'(min_window_cfg);
        if (need > DEMAND_CAP)
            need = DEMAND_CAP;
        top     = need * UPPER_MULT;
        want_lo = need[15:0];
        want_hi = (top > 64'hFFFF) ? 16'hFFFF : top[15:0];
        if (win_lower != want_lo || win_upper != want_hi) begin
            // a pinned lower bound only ever moves up
            if (!win_pinned || want_lo > win_lower)
                win_lower = want_lo;
            win_upper = want_hi;
            if (win_limit < win_lower)
                win_limit = clamp_window(32'(win_lower));
        end
    endfunction

    function automatic window_status_t predict_event(input logic [3:0]  op,
                                                     input logic [15:0] value,
                                                     input logic [15:0] rate,
                                                     input logic [15:0] avg,
                                                     input logic [15:0] dev);
        window_status_t res;
        int unsigned    lim;
        int unsigned    shrink;
        lim    = 32'(win_limit);
        shrink = 0;
        res.ok = 1'b1;
        case (op)
            rwc_pkg::OP_INCREMENT: begin
                if (win_outstanding >= win_limit)
                    res.ok = 1'b0;
                else
                    win_outstanding = win_outstanding + 16'd1;
            end
            rwc_pkg::OP_DECREMENT: begin
                if (win_outstanding == 16'd0)
                    res.ok = 1'b0;
                else
                    win_outstanding = win_outstanding - 16'd1;
            end
            rwc_pkg::OP_BURST: begin
                if (win_started)
                    win_limit = clamp_window(lim + (lim + 1) / 2);
                else
                    res.ok = 1'b0;
            end
            rwc_pkg::OP_WITHHOLD: begin
                if (win_started && win_limit >= win_lower)
                    shrink = (lim - 32'(win_lower) + 1) / 2;
                if (shrink != 0)
                    win_limit = clamp_window(lim - shrink);
                else
                    res.ok = 1'b0;
            end
            rwc_pkg::OP_MARK_LOWER: begin
                win_pinned = 1'b1;
                win_lower  = value;
                retarget_bounds();
            end
            rwc_pkg::OP_DELAY_UPDATE: begin
                stat_avg = avg;
                stat_dev = dev;
                if (win_started)
                    retarget_bounds();
            end
            rwc_pkg::OP_RATE_UPDATE: begin
                stat_rate   = rate;
                win_started = 1'b1;
                retarget_bounds();
            end
            rwc_pkg::OP_INITIALIZE: begin
                win_lower = {8'd0, min_window_cfg};
                if (value > win_upper)
                    win_upper = value;
                win_limit = clamp_window(32'(value));
            end
            rwc_pkg::OP_CLEAR: begin
                win_started     = 1'b0;
                win_pinned      = 1'b0;
                win_outstanding = 16'd0;
                win_lower       = {8'd0, min_window_cfg};
                win_limit       = {8'd0, min_window_cfg};
                win_upper       = rwc_pkg::CLEAR_UPPER;
            end
            default: res.ok = 1'b0;
        endcase
        res.outstanding = win_outstanding;
        res.window      = win_limit;
        res.lower       = win_lower;
        res.upper       = win_upper;
        return res;
    endfunction

    // Mostly typical magnitudes, with zero, all-ones and full-range values mixed in.
    function automatic logic [15:0] random_field(input int unsigned typical_max);
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom);
            default: return 16'($urandom_range(1, typical_max));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Request side: one request per call, valid held until accepted.
    // Returns on the accepting edge with valid still high.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [3:0]  op,
                                input logic [15:0] value,
                                input logic [15:0] rate,
                                input logic [15:0] avg,
                                input logic [15:0] dev);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 13);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_value     <= value;
        s_rate      <= rate;
        s_delay_avg <= avg;
        s_delay_dev <= dev;
        pending_results.push_back(predict_event(op, value, rate, avg, dev));
        requests_sent++;
        if (op > rwc_pkg::OP_CLEAR)
            unknown_sent++;
        do
            @(posedge aclk);
        while (!s_ready);
    endtask

    // Stop sending and wait for every outstanding result, plus pipeline slack.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idling(input bit on);
        @(negedge aclk);
        idle_on = on;
        @(posedge aclk);
    endtask

    // min_window changes only with the block idle
    task automatic set_min_window(input logic [7:0] setting);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= setting;
        @(posedge aclk);
        cfg_wr_en      <= 1'b0;
        min_window_cfg  = setting;
        settings_used++;
    endtask

    // ------------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------------

    // decrement at zero, burst and withhold before any rate update
    task automatic test_unstarted_refusals();
        send_request(rwc_pkg::OP_DECREMENT, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(rwc_pkg::OP_BURST,     16'd0, 16'd0, 16'd0, 16'd0);
        send_request(rwc_pkg::OP_WITHHOLD,  16'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // fill the reset window, then one increment too many
    task automatic test_window_full();
        repeat (int'(rwc_pkg::MIN_WINDOW_RST) + 1)
            send_request(rwc_pkg::OP_INCREMENT, 16'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // start at rate 0, grow once, shrink down to a zero step
    task automatic test_burst_withhold();
        send_request(rwc_pkg::OP_RATE_UPDATE, 16'd0, 16'd0, 16'd0, 16'd0);
        send_request(rwc_pkg::OP_BURST,       16'd0, 16'd0, 16'd0, 16'd0);
        repeat (3)
            send_request(rwc_pkg::OP_WITHHOLD, 16'd0, 16'd0, 16'd0, 16'd0);
    endtask

    // pinned lower above upper (window ends below lower), then demand extremes
    task automatic test_bound_extremes();
        send_request(rwc_pkg::OP_MARK_LOWER,   16'hFFFF, 16'd0,    16'd0,    16'd0);
        send_request(rwc_pkg::OP_WITHHOLD,     16'd0,    16'd0,    16'd0,    16'd0);
        send_request(rwc_pkg::OP_MARK_LOWER,   16'd0,    16'd0,    16'd0,    16'd0);
        send_request(rwc_pkg::OP_DELAY_UPDATE, 16'd0,    16'd0,    16'hFFFF, 16'hFFFF);
        send_request(rwc_pkg::OP_RATE_UPDATE,  16'd0,    16'hFFFF, 16'd0,    16'd0);
        send_request(rwc_pkg::OP_RATE_UPDATE,  16'd0,    16'd0,    16'd0,    16'd0);
    endtask

    task automatic test_init_and_clear();
        send_request(rwc_pkg::OP_INITIALIZE, 16'd0,    16'd0, 16'd0, 16'd0);
        send_request(rwc_pkg::OP_INITIALIZE, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_request(rwc_pkg::OP_CLEAR,      16'd0,    16'd0, 16'd0, 16'd0);
    endtask

    task automatic test_unknown_ops();
        send_request(OP_UNKNOWN_LO, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(OP_UNKNOWN_HI, 16'd0,    16'd0,    16'd0,    16'd0);
    endtask

    // ------------------------------------------------------------------------
    // Random traffic: mostly a started window seeing counting, bursts,
    // withholds and statistic updates; clears, pins, initializes and
    // unknown codes as noise. Unknown codes do not count toward the total.
    // ------------------------------------------------------------------------
    task automatic test_random_traffic(input int unsigned count);
        int unsigned done;
        int unsigned pick;
        logic [3:0]  op;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(0, 99);
            if (!win_started && pick < 50)
                op = rwc_pkg::OP_RATE_UPDATE;
            else if (pick < 25)
                op = rwc_pkg::OP_INCREMENT;
            else if (pick < 40)
                op = rwc_pkg::OP_DECREMENT;
            else if (pick < 50)
                op = rwc_pkg::OP_BURST;
            else if (pick < 60)
                op = rwc_pkg::OP_WITHHOLD;
            else if (pick < 70)
                op = rwc_pkg::OP_DELAY_UPDATE;
            else if (pick < 78)
                op = rwc_pkg::OP_RATE_UPDATE;
            else if (pick < 84)
                op = rwc_pkg::OP_MARK_LOWER;
            else if (pick < 90)
                op = rwc_pkg::OP_INITIALIZE;
            else if (pick < 93)
                op = rwc_pkg::OP_CLEAR;
            else if (pick < 96)
                op = 4'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
            else
                op = 4'($urandom_range(0, 15));
            send_request(op, random_field(80), random_field(15360),
                         random_field(8000), random_field(2000));
            if (op <= rwc_pkg::OP_CLEAR)
                done++;
        end
    endtask

    // Receiver holds off, counting down LONG_HOLD, while requests keep coming,
    // so the pipeline fills and s_ready drops.
    task automatic test_output_stall();
        drain_results();
        @(negedge aclk);
        hold_seq++;
        @(posedge aclk);
        test_random_traffic(40);
    endtask

    // ------------------------------------------------------------------------
    // Result side ready: random stall bursts, plus the long hold on request
    // ------------------------------------------------------------------------
    int          hold_seen = 0;
    int unsigned sink_wait = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_wait <= 0;
        end else if (hold_seen != hold_seq) begin
            hold_seen <= hold_seq;
            sink_wait <= LONG_HOLD;
            m_ready   <= 1'b0;
        end else if (sink_wait != 0) begin
            sink_wait <= sink_wait - 1;
            m_ready   <= (sink_wait == 1);
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_wait <= $urandom_range(1, 13);
            m_ready   <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: in-order compare against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        window_status_t got;
        window_status_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_ok, m_outstanding, m_window, m_lower_bound, m_upper_bound};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("Result with nothing pending: ok=%0b out=%0d win=%0d lo=%0d hi=%0d",
                             got.ok, got.outstanding, got.window, got.lower, got.upper);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (!want.ok)
                    refusals++;
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d at %0t", results_checked, $realtime);
                        $display("  expected ok=%0b out=%0d win=%0d lo=%0d hi=%0d",
                                 want.ok, want.outstanding, want.window, want.lower,
                                 want.upper);
                        $display("  actual   ok=%0b out=%0d win=%0d lo=%0d hi=%0d",
                                 got.ok, got.outstanding, got.window, got.lower, got.upper);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any handshake on either side
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("request_window_controller verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(1'b1);

        // directed, at the reset min_window
        test_unstarted_refusals();
        test_window_full();
        test_burst_withhold();
        test_bound_extremes();
        test_init_and_clear();
        test_unknown_ops();

        // random at the smallest nonzero and the largest floor
        set_min_window(8'd1);
        test_random_traffic(150);
        set_min_window(8'hFF);
        test_random_traffic(120);

        // back pressure through the whole pipeline
        set_min_window(8'($urandom_range(2, 254)));
        test_output_stall();

        // last stretch without idling on either side
        set_min_window(8'($urandom_range(2, 254)));
        set_idling(1'b0);
        test_random_traffic(150);

        drain_results();
        $display("Sent %0d requests (%0d with unknown codes) over %0d min_window settings.",
                 requests_sent, unknown_sent, settings_used);
        $display("Checked %0d results, %0d refused events, %0d mismatches.",
                 results_checked, refusals, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("request_window_controller verification clean");
        else
            $display("request_window_controller verification failed");
        $finish;
    end

endmodule
